// ===== rtl/core/time_ordered_event_queue_macros.svh =====
// Assertion macros used by the event queue top module.
`ifndef TIME_ORDERED_EVENT_QUEUE_MACROS_SVH
`define TIME_ORDERED_EVENT_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TOEQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TOEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/toeq_pkg.sv =====
package toeq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int TIME_BITS   = 31;
  localparam int ID_BITS     = 8;
  localparam int KIND_BITS   = 2;
  localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1);
  localparam int ERR_BITS    = 2;
  localparam int OP_BITS     = 3;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_POP    = 1'b1;

  localparam logic [ERR_BITS-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_BITS-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_BITS-1:0] ERR_EMPTY = 2'd2;

  localparam logic [OP_BITS-1:0] OP_NONE      = 3'd0;
  localparam logic [OP_BITS-1:0] OP_INSERT    = 3'd1;
  localparam logic [OP_BITS-1:0] OP_POP       = 3'd2;
  localparam logic [OP_BITS-1:0] OP_DROP_FULL = 3'd3;
  localparam logic [OP_BITS-1:0] OP_POP_EMPTY = 3'd4;

  typedef struct packed {
    logic [TIME_BITS-1:0] ev_time;
    logic [ID_BITS-1:0]   ev_id;
    logic [KIND_BITS-1:0] ev_kind;
  } entry_t;

  typedef struct packed {
    logic               capture;
    logic [OP_BITS-1:0] op;
  } dp_ctrl_t;

  typedef struct packed {
    logic is_pop;
    logic full;
    logic empty;
  } dp_status_t;

endpackage

// ===== rtl/core/time_ordered_event_queue.sv =====
// Channel   Handshake            Ports
// input     start & !busy        in_cmd, in_event_time, in_proc_id, in_transition
// result    out_valid (1 cycle)  out_pop_valid, out_time, out_proc_id, out_transition,
//                                out_head_valid, out_head_time, out_occupancy,
//                                out_error_code
//
// Each item takes two cycles: one to capture it and one for the parallel
// compare-and-shift over all queue slots, after which the result is shown.
// busy is high during the shift cycle, and a new item may be taken in the
// cycle that shows the previous result, so one item completes every two cycles.
// Synchronous reset empties the queue; slot contents are not cleared.
// The receiver cannot stall, so nothing holds the result stage.
module time_ordered_event_queue (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_cmd,
  input  logic [toeq_pkg::TIME_BITS-1:0]    in_event_time,
  input  logic [toeq_pkg::ID_BITS-1:0]      in_proc_id,
  input  logic [toeq_pkg::KIND_BITS-1:0]    in_transition,
  output logic                              out_valid,
  output logic                              out_pop_valid,
  output logic [toeq_pkg::TIME_BITS-1:0]    out_time,
  output logic [toeq_pkg::ID_BITS-1:0]      out_proc_id,
  output logic [toeq_pkg::KIND_BITS-1:0]    out_transition,
  output logic                              out_head_valid,
  output logic [toeq_pkg::TIME_BITS-1:0]    out_head_time,
  output logic [toeq_pkg::CNT_BITS-1:0]     out_occupancy,
  output logic [toeq_pkg::ERR_BITS-1:0]     out_error_code
);
  import toeq_pkg::*;
`include "time_ordered_event_queue_macros.svh"

  dp_ctrl_t   ctrl;
  dp_status_t status;

  toeq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .status    (status),
    .ctrl      (ctrl),
    .out_valid (out_valid)
  );

  toeq_datapath u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctrl           (ctrl),
    .status         (status),
    .in_cmd         (in_cmd),
    .in_event_time  (in_event_time),
    .in_proc_id     (in_proc_id),
    .in_transition  (in_transition),
    .out_pop_valid  (out_pop_valid),
    .out_time       (out_time),
    .out_proc_id    (out_proc_id),
    .out_transition (out_transition),
    .out_head_valid (out_head_valid),
    .out_head_time  (out_head_time),
    .out_occupancy  (out_occupancy),
    .out_error_code (out_error_code)
  );

  `TOEQ_ASSERT_NEXT(a_accept_then_busy, start && !busy, busy && !out_valid, "accepted item did not start work")
  `TOEQ_ASSERT_NEXT(a_busy_then_result, busy, out_valid && !busy, "work cycle gave no result")
  `TOEQ_ASSERT_SAME(a_occ_bound, out_valid, out_occupancy <= CNT_BITS'(QUEUE_DEPTH), "occupancy beyond depth")
  `TOEQ_ASSERT_SAME(a_full_drop, out_valid && (out_error_code == ERR_FULL), !out_pop_valid && (out_occupancy == CNT_BITS'(QUEUE_DEPTH)), "dropped insert while not full")
  `TOEQ_ASSERT_SAME(a_pop_ok, out_valid && out_pop_valid, (out_error_code == ERR_OK) && (out_head_valid == (out_occupancy != '0)), "pop result inconsistent")

endmodule

// ===== rtl/core/toeq_ctrl.sv =====
module toeq_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  toeq_pkg::dp_status_t status,
  output toeq_pkg::dp_ctrl_t  ctrl,
  output logic                out_valid
);
  import toeq_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r;
  logic state_nxt;
  logic out_valid_r;
  logic out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    ctrl.capture  = 1'b0;
    ctrl.op       = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          ctrl.capture = 1'b1;
          state_nxt    = S_EXEC;
        end
      end
      S_EXEC: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
        if (status.is_pop) begin
          ctrl.op = status.empty ? OP_POP_EMPTY : OP_POP;
        end else begin
          ctrl.op = status.full ? OP_DROP_FULL : OP_INSERT;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = (state_r == S_EXEC);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/toeq_datapath.sv =====
module toeq_datapath (
  input  logic                              clk,
  input  logic                              rst_n,
  input  toeq_pkg::dp_ctrl_t                ctrl,
  output toeq_pkg::dp_status_t              status,
  input  logic                              in_cmd,
  input  logic [toeq_pkg::TIME_BITS-1:0]    in_event_time,
  input  logic [toeq_pkg::ID_BITS-1:0]      in_proc_id,
  input  logic [toeq_pkg::KIND_BITS-1:0]    in_transition,
  output logic                              out_pop_valid,
  output logic [toeq_pkg::TIME_BITS-1:0]    out_time,
  output logic [toeq_pkg::ID_BITS-1:0]      out_proc_id,
  output logic [toeq_pkg::KIND_BITS-1:0]    out_transition,
  output logic                              out_head_valid,
  output logic [toeq_pkg::TIME_BITS-1:0]    out_head_time,
  output logic [toeq_pkg::CNT_BITS-1:0]     out_occupancy,
  output logic [toeq_pkg::ERR_BITS-1:0]     out_error_code
);
  import toeq_pkg::*;

  logic                 cmd_r;
  entry_t               req_r;
  entry_t               entries_r   [QUEUE_DEPTH];
  entry_t               entries_nxt [QUEUE_DEPTH];
  logic [CNT_BITS-1:0]  count_r;
  logic [CNT_BITS-1:0]  count_nxt;
  logic [QUEUE_DEPTH-1:0] after_slot;
  logic                 update;

  logic                 pop_valid_r, pop_valid_nxt;
  entry_t               popped_r, popped_nxt;
  logic                 head_valid_r;
  logic [TIME_BITS-1:0] head_time_r;
  logic [ERR_BITS-1:0]  err_r, err_nxt;

  assign status.is_pop = (cmd_r == CMD_POP);
  assign status.full   = (count_r == CNT_BITS'(QUEUE_DEPTH));
  assign status.empty  = (count_r == '0);

  // A new event goes after every stored event with an equal or earlier time;
  // since the entries are sorted, these slots form a prefix.
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      after_slot[i] = (CNT_BITS'(i) < count_r) && (req_r.ev_time >= entries_r[i].ev_time);
    end
  end

  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      entries_nxt[i] = entries_r[i];
    end
    count_nxt     = count_r;
    update        = 1'b0;
    pop_valid_nxt = 1'b0;
    popped_nxt    = '0;
    err_nxt       = ERR_OK;
    unique case (ctrl.op)
      OP_INSERT: begin
        update    = 1'b1;
        count_nxt = count_r + 1'b1;
        if (!after_slot[0]) begin
          entries_nxt[0] = req_r;
        end
        for (int i = 1; i < QUEUE_DEPTH; i++) begin
          if (!after_slot[i]) begin
            if (after_slot[i-1]) begin
              entries_nxt[i] = req_r;
            end else begin
              entries_nxt[i] = entries_r[i-1];
            end
          end
        end
      end
      OP_POP: begin
        update        = 1'b1;
        count_nxt     = count_r - 1'b1;
        pop_valid_nxt = 1'b1;
        popped_nxt    = entries_r[0];
        for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
          entries_nxt[i] = entries_r[i+1];
        end
      end
      OP_DROP_FULL: err_nxt = ERR_FULL;
      OP_POP_EMPTY: err_nxt = ERR_EMPTY;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_r         <= in_cmd;
      req_r.ev_time <= in_event_time;
      req_r.ev_id   <= in_proc_id;
      req_r.ev_kind <= in_transition;
    end
    if (update) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        entries_r[i] <= entries_nxt[i];
      end
    end
    if (ctrl.op != OP_NONE) begin
      pop_valid_r  <= pop_valid_nxt;
      popped_r     <= popped_nxt;
      err_r        <= err_nxt;
      head_valid_r <= (count_nxt != '0);
      head_time_r  <= (count_nxt != '0) ? entries_nxt[0].ev_time : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign out_pop_valid  = pop_valid_r;
  assign out_time       = popped_r.ev_time;
  assign out_proc_id    = popped_r.ev_id;
  assign out_transition = popped_r.ev_kind;
  assign out_head_valid = head_valid_r;
  assign out_head_time  = head_time_r;
  assign out_occupancy  = count_r;
  assign out_error_code = err_r;

endmodule

// ===== verif/tb_time_ordered_event_queue.sv =====
module tb_time_ordered_event_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import toeq_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 400;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  typedef struct {
    logic                 cmd;
    logic [TIME_BITS-1:0] ev_time;
    logic [ID_BITS-1:0]   proc_id;
    logic [KIND_BITS-1:0] kind;
    int                   gap_pct;
  } event_cmd_t;

  typedef struct {
    logic                 pop_valid;
    logic [TIME_BITS-1:0] ev_time;
    logic [ID_BITS-1:0]   proc_id;
    logic [KIND_BITS-1:0] kind;
    logic                 head_valid;
    logic [TIME_BITS-1:0] head_time;
    logic [CNT_BITS-1:0]  occupancy;
    logic [ERR_BITS-1:0]  error_code;
  } event_report_t;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 start         = 1'b0;
  logic                 busy;
  logic                 in_cmd        = CMD_INSERT;
  logic [TIME_BITS-1:0] in_event_time = '0;
  logic [ID_BITS-1:0]   in_proc_id    = '0;
  logic [KIND_BITS-1:0] in_transition = '0;
  logic                 out_valid;
  logic                 out_pop_valid;
  logic [TIME_BITS-1:0] out_time;
  logic [ID_BITS-1:0]   out_proc_id;
  logic [KIND_BITS-1:0] out_transition;
  logic                 out_head_valid;
  logic [TIME_BITS-1:0] out_head_time;
  logic [CNT_BITS-1:0]  out_occupancy;
  logic [ERR_BITS-1:0]  out_error_code;

  entry_t        sched_slots [QUEUE_DEPTH];
  int            sched_count = 0;
  event_cmd_t    pending_cmds [$];
  event_report_t expected_reports [$];
  int            errors      = 0;
  int            idle_cycles = 0;
  logic          took_item   = 1'b0;

  time_ordered_event_queue dut (.*);

  always #1 clk = ~clk;

  // Applies one item to the scheduler copy and returns the report it should produce.
  function automatic event_report_t advance_schedule(event_cmd_t c);
    event_report_t r;
    int pos;
    int i;
    r = '{default: '0};
    if (c.cmd == CMD_INSERT) begin
      if (sched_count >= QUEUE_DEPTH) begin
        r.error_code = ERR_FULL;
      end else begin
        pos = 0;
        while (pos < sched_count && c.ev_time >= sched_slots[pos].ev_time) pos++;
        for (i = sched_count; i > pos; i--) sched_slots[i] = sched_slots[i-1];
        sched_slots[pos].ev_time = c.ev_time;
        sched_slots[pos].ev_id   = c.proc_id;
        sched_slots[pos].ev_kind = c.kind;
        sched_count++;
      end
    end else if (sched_count == 0) begin
      r.error_code = ERR_EMPTY;
    end else begin
      r.pop_valid = 1'b1;
      r.ev_time   = sched_slots[0].ev_time;
      r.proc_id   = sched_slots[0].ev_id;
      r.kind      = sched_slots[0].ev_kind;
      for (i = 1; i < sched_count; i++) sched_slots[i-1] = sched_slots[i];
      sched_count--;
    end
    r.head_valid = (sched_count > 0);
    r.head_time  = (sched_count > 0) ? sched_slots[0].ev_time : '0;
    r.occupancy  = CNT_BITS'(sched_count);
    return r;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic check_report();
    event_report_t want;
    if (expected_reports.size() == 0) begin
      $display("%0t: unexpected result, expected none, actual time %0h id %0h err %0h",
               $time, out_time, out_proc_id, out_error_code);
      errors++;
    end else begin
      want = expected_reports.pop_front();
      compare_field("out_pop_valid", 64'(want.pop_valid), 64'(out_pop_valid));
      compare_field("out_time", 64'(want.ev_time), 64'(out_time));
      compare_field("out_proc_id", 64'(want.proc_id), 64'(out_proc_id));
      compare_field("out_transition", 64'(want.kind), 64'(out_transition));
      compare_field("out_head_valid", 64'(want.head_valid), 64'(out_head_valid));
      compare_field("out_head_time", 64'(want.head_time), 64'(out_head_time));
      compare_field("out_occupancy", 64'(want.occupancy), 64'(out_occupancy));
      compare_field("out_error_code", 64'(want.error_code), 64'(out_error_code));
    end
  endtask

  task automatic queue_cmd(logic cmd, logic [TIME_BITS-1:0] t, logic [ID_BITS-1:0] id,
                           logic [KIND_BITS-1:0] kind, int gap_pct);
    event_cmd_t c;
    c.cmd     = cmd;
    c.ev_time = t;
    c.proc_id = id;
    c.kind    = kind;
    c.gap_pct = gap_pct;
    pending_cmds = {pending_cmds, c};
  endtask

  function automatic logic [TIME_BITS-1:0] pick_time();
    int sel;
    sel = $urandom_range(9);
    if (sel < 4) return TIME_BITS'($urandom_range(31));
    if (sel < 8) return TIME_BITS'($urandom);
    if (sel == 8) return '0;
    return TIME_MAX;
  endfunction

  always @(negedge clk) begin
    if (rst_n && (!start || took_item)) begin
      if (pending_cmds.size() != 0 && $urandom_range(99) >= pending_cmds[0].gap_pct) begin
        start         <= 1'b1;
        in_cmd        <= pending_cmds[0].cmd;
        in_event_time <= pending_cmds[0].ev_time;
        in_proc_id    <= pending_cmds[0].proc_id;
        in_transition <= pending_cmds[0].kind;
        void'(pending_cmds.pop_front());
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    took_item <= rst_n && start && !busy;
    if (rst_n && start && !busy) begin
      expected_reports = {expected_reports,
        advance_schedule('{in_cmd, in_event_time, in_proc_id, in_transition, 0})};
    end
    if (rst_n && ((start && !busy) ||
                  (out_valid === 1'b1 && expected_reports.size() != 0))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (rst_n && out_valid === 1'b1) check_report();
  end

  initial begin
    int phase;
    int n;
    int burst;
    int insert_pct;
    int gap;
    int k;

    // Pop from an empty queue, extreme fields, equal-time ties, then fill, overflow and pop.
    queue_cmd(CMD_POP, TIME_MAX, '1, '1, 0);
    queue_cmd(CMD_INSERT, TIME_MAX, 8'd255, 2'd3, 0);
    queue_cmd(CMD_INSERT, '0, 8'd0, 2'd0, 0);
    queue_cmd(CMD_INSERT, TIME_BITS'(100), 8'd1, 2'd1, 0);
    queue_cmd(CMD_INSERT, TIME_BITS'(100), 8'd2, 2'd2, 0);
    queue_cmd(CMD_INSERT, TIME_BITS'(100), 8'd3, 2'd3, 0);
    queue_cmd(CMD_INSERT, TIME_MAX, 8'd7, 2'd0, 0);
    queue_cmd(CMD_INSERT, '0, 8'd9, 2'd2, 0);
    queue_cmd(CMD_POP, '0, '0, '0, 0);
    queue_cmd(CMD_POP, '0, '0, '0, 0);
    for (k = 0; k < 11; k++) begin
      queue_cmd(CMD_INSERT, TIME_BITS'($urandom_range(200)), ID_BITS'($urandom),
                KIND_BITS'($urandom), 0);
    end
    queue_cmd(CMD_INSERT, TIME_BITS'(50), 8'hAA, 2'd1, 0);
    queue_cmd(CMD_POP, '0, '0, '0, 0);
    queue_cmd(CMD_POP, '0, '0, '0, 0);

    // Random part: bursts that lean toward filling, draining or neither, so the
    // queue can swing between empty and full; phases 1 and 3 add random idle gaps.
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        1: gap = 55;
        3: gap = 7;
        default: gap = 0;
      endcase
      n = 0;
      while (n < PHASE_ITEMS) begin
        burst = $urandom_range(8, 40);
        case ($urandom_range(2))
          0: insert_pct = 85;
          1: insert_pct = 15;
          default: insert_pct = 50;
        endcase
        for (k = 0; k < burst && n < PHASE_ITEMS; k++) begin
          queue_cmd(($urandom_range(99) < insert_pct) ? CMD_INSERT : CMD_POP, pick_time(),
                    ID_BITS'($urandom), KIND_BITS'($urandom), gap);
          n++;
        end
      end
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while ((pending_cmds.size() != 0 || start || expected_reports.size() != 0)
           && idle_cycles < IDLE_LIMIT) @(posedge clk);

    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      if (errors == 0) begin
        $display("tb: success");
      end else begin
        $display("tb: failure");
      end
      $finish;
    end
  end

endmodule
